@@ src/ptea_pkg.sv @@
// package for the table entry allocator: item structs, operation and status codes,
// controller/datapath command and status structs
// no dependencies
package ptea_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  // reach of the index fields
  localparam int IDX_BITS       = 6;
  localparam int BND_W          = IDX_BITS + 1;
  // entries examined per cycle by the free-slot scan
  localparam int LANES          = 8;

  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INDEX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_OPTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_CTRL    = 2'd2;

  localparam logic [BND_W-1:0] MAX_INDEX_RST = 7'd64;
  localparam logic [7:0]       ALLOWED_RST   = 8'hff;
  localparam logic [7:0]       FLOW_CTRL_RST = 8'h01;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_DISABLE = 2'd2,
    FUNC_ENABLE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_IN_USE    = 3'd1,
    ST_FULL      = 3'd2,
    ST_INVALID   = 3'd3,
    ST_EQ_NEEDED = 3'd4
  } status_t;

  typedef struct packed {
    func_t                func;
    logic [IDX_BITS-1:0]  index;
    logic                 any_index;
    logic [7:0]           options;
    logic                 eq_present;
    logic [7:0]           eq_id;
    logic                 entry_busy;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [IDX_BITS-1:0]  index_out;
    logic                 released_eq_valid;
    logic [7:0]           released_eq_id;
  } out_item_t;

  typedef struct packed {
    logic [7:0] options;
    logic       eq_present;
    logic [7:0] eq_id;
  } entry_t;

  typedef struct packed {
    logic load;   // latch request, read entry storage
    logic check;  // evaluate request, commit unless a scan is needed
    logic step;   // one scan step over the in-use bitmap
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_search;
    logic scan_done;
  } dp_stat_t;

endpackage

@@ src/portal_table_entry_allocator_top.sv @@
// top level of the table entry allocator: controller plus datapath, port assertions
// depends on ptea_pkg, ptea_ctrl, ptea_dp
//
//  channel  | strobe / handshake        | payload
//  ---------+---------------------------+------------------------------
//  request  | start, busy (start & !busy)| in_data   (ptea_pkg::in_item_t)
//  result   | out_valid, one cycle      | out_data  (ptea_pkg::out_item_t)
//  config   | cfg_we                    | cfg_index, cfg_wdata
//
// free, enable, disable and allocate at a given index: the request is loaded, then
// checked in S_CHECK, and out_valid comes from the result register. allocate of any
// index: the in-use bitmap is scanned eight entries per cycle from the last allocation.
// one transaction at a time; a new start is taken in the cycle out_valid is high.
// reset clears the in-use and enabled bitmaps at once; entry storage is not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle.
module portal_table_entry_allocator_top #(
  parameter int TABLE_SIZE = ptea_pkg::TABLE_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  ptea_pkg::in_item_t               in_data,
  output logic                             out_valid,
  output ptea_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [ptea_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptea_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ptea_pkg::ctrl_cmd_t cmd;
  ptea_pkg::dp_stat_t  stat;

  ptea_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ptea_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ptea_pkg::ST_OK) |->
      (out_data.index_out == '0) && !out_data.released_eq_valid)
    else $error("error result carries an index or released queue");
`endif

endmodule

@@ src/ptea_ctrl.sv @@
// controller for the table entry allocator: sequences load, check and scan steps
// depends on ptea_pkg
module ptea_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ptea_pkg::dp_stat_t    stat,
  output ptea_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = stat.need_search ? S_SEARCH : S_IDLE;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

@@ src/ptea_dp.sv @@
// datapath for the table entry allocator: config registers, in-use/enabled bitmaps,
// entry storage, next-fit scan and result register; depends on ptea_pkg
module ptea_dp #(
  parameter int TABLE_SIZE = ptea_pkg::TABLE_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ptea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptea_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  ptea_pkg::in_item_t                 in_data,
  input  ptea_pkg::ctrl_cmd_t                cmd,
  output ptea_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output ptea_pkg::out_item_t                out_data
);

  localparam int IDX_LIM = 1 << ptea_pkg::IDX_BITS;
  localparam int DEPTH   = (TABLE_SIZE < IDX_LIM) ? TABLE_SIZE : IDX_LIM;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int LANES   = ptea_pkg::LANES;
  localparam int BND_W   = ptea_pkg::BND_W;
  localparam int SUM_W   = $clog2(DEPTH + LANES) + 1;
  localparam int CNT_W   = $clog2(DEPTH + LANES + 1);

  localparam logic [BND_W-1:0] DEPTH_B   = BND_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  // configuration
  logic [BND_W-1:0] max_index_r;
  logic [7:0]       allowed_r;
  logic [7:0]       flow_ctrl_r;

  // table state
  logic [DEPTH-1:0]  in_use_r;
  logic [DEPTH-1:0]  enabled_r;
  logic [IDX_W-1:0]  last_r;
  ptea_pkg::entry_t  mem [DEPTH];

  // request under work
  ptea_pkg::in_item_t req_r;
  ptea_pkg::entry_t   rd_r;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   cnt_r;

  logic                 out_valid_r;
  ptea_pkg::out_item_t  out_r;

  logic [BND_W-1:0] lim;
  logic [IDX_W-1:0] req_idx;
  logic             in_range;
  logic             used;
  logic             opt_bad;
  logic             eq_bad;
  logic             is_alloc;
  logic             need_search;

  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             exhausted;

  logic                 fire;
  ptea_pkg::out_item_t  res;
  logic                 wr_alloc;
  logic                 wr_free;
  logic                 wr_enable;
  logic                 en_val;
  logic [IDX_W-1:0]     wr_slot;
  logic [IDX_W-1:0]     ptr_init;
  logic [SUM_W-1:0]     adv_sum;

  assign lim      = (max_index_r < DEPTH_B) ? max_index_r : DEPTH_B;
  assign req_idx  = req_r.index[IDX_W-1:0];
  assign in_range = ({1'b0, req_r.index} < lim);
  assign used     = in_range && in_use_r[req_idx];
  assign opt_bad  = |(req_r.options & ~allowed_r);
  assign eq_bad   = (|(req_r.options & flow_ctrl_r)) && !req_r.eq_present;
  assign is_alloc = (req_r.func == ptea_pkg::FUNC_ALLOC);
  assign need_search = is_alloc && !opt_bad && !eq_bad && req_r.any_index;

  // scan lanes: positions ptr, ptr+1, ... modulo the table depth
  always_comb begin
    logic [CNT_W-1:0] k;
    logic [SUM_W-1:0] s;
    logic [IDX_W-1:0] cand;
    logic             lane_ok;
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < LANES; j++) begin
      k       = cnt_r + CNT_W'(j);
      lane_ok = (k < DEPTH_C);
      s       = SUM_W'(ptr_r) + SUM_W'(j);
      if (s >= DEPTH_S) begin
        s = s - DEPTH_S;
      end
      if (s >= DEPTH_S) begin
        s = '0;
      end
      cand = s[IDX_W-1:0];
      if (!found && lane_ok && (BND_W'(cand) < lim) && !in_use_r[cand]) begin
        found     = 1'b1;
        found_idx = cand;
      end
    end
  end

  assign exhausted = ((cnt_r + CNT_W'(LANES)) >= DEPTH_C);

  assign stat.need_search = need_search;
  assign stat.scan_done   = found || exhausted;

  assign ptr_init = (last_r == LAST_IDX) ? '0 : last_r + IDX_W'(1);

  always_comb begin
    adv_sum = SUM_W'(ptr_r) + SUM_W'(LANES);
    if (adv_sum >= DEPTH_S) begin
      adv_sum = adv_sum - DEPTH_S;
    end
    ptr_nxt = adv_sum[IDX_W-1:0];
  end

  // result and table update
  always_comb begin
    fire      = 1'b0;
    res       = '0;
    res.status = ptea_pkg::ST_OK;
    wr_alloc  = 1'b0;
    wr_free   = 1'b0;
    wr_enable = 1'b0;
    en_val    = 1'b0;
    wr_slot   = req_idx;
    if (cmd.check && !need_search) begin
      fire = 1'b1;
      if (is_alloc) begin
        if (opt_bad) begin
          res.status = ptea_pkg::ST_INVALID;
        end else if (eq_bad) begin
          res.status = ptea_pkg::ST_EQ_NEEDED;
        end else if (!in_range) begin
          res.status = ptea_pkg::ST_INVALID;
        end else if (used) begin
          res.status = ptea_pkg::ST_IN_USE;
        end else begin
          wr_alloc      = 1'b1;
          res.index_out = req_r.index;
        end
      end else if (!used) begin
        res.status = ptea_pkg::ST_INVALID;
      end else if (req_r.func == ptea_pkg::FUNC_FREE) begin
        if (req_r.entry_busy) begin
          res.status = ptea_pkg::ST_IN_USE;
        end else begin
          wr_free       = 1'b1;
          res.index_out = req_r.index;
          if (rd_r.eq_present) begin
            res.released_eq_valid = 1'b1;
            res.released_eq_id    = rd_r.eq_id;
          end
        end
      end else begin
        wr_enable     = 1'b1;
        en_val        = (req_r.func == ptea_pkg::FUNC_ENABLE);
        res.index_out = req_r.index;
      end
    end else if (cmd.step && (found || exhausted)) begin
      fire = 1'b1;
      if (found) begin
        wr_alloc      = 1'b1;
        wr_slot       = found_idx;
        res.index_out = ptea_pkg::IDX_BITS'(found_idx);
      end else begin
        res.status = ptea_pkg::ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_index_r <= ptea_pkg::MAX_INDEX_RST;
      allowed_r   <= ptea_pkg::ALLOWED_RST;
      flow_ctrl_r <= ptea_pkg::FLOW_CTRL_RST;
      in_use_r    <= '0;
      enabled_r   <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ptea_pkg::CFG_MAX_INDEX:    max_index_r <= cfg_wdata[BND_W-1:0];
          ptea_pkg::CFG_ALLOWED_OPTS: allowed_r   <= cfg_wdata;
          ptea_pkg::CFG_FLOW_CTRL:    flow_ctrl_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (wr_alloc) begin
        in_use_r[wr_slot]  <= 1'b1;
        enabled_r[wr_slot] <= 1'b1;
        last_r             <= wr_slot;
      end
      if (wr_free) begin
        in_use_r[wr_slot]  <= 1'b0;
        enabled_r[wr_slot] <= 1'b0;
      end
      if (wr_enable) begin
        enabled_r[wr_slot] <= en_val;
      end
      out_valid_r <= fire;
    end
  end

  // entry storage and request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      rd_r  <= mem[in_data.index[IDX_W-1:0]];
    end
    if (wr_alloc) begin
      mem[wr_slot] <= '{options:    req_r.options,
                        eq_present: req_r.eq_present,
                        eq_id:      req_r.eq_present ? req_r.eq_id : 8'd0};
    end
    if (cmd.check) begin
      ptr_r <= ptr_init;
      cnt_r <= '0;
    end else if (cmd.step) begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_r + CNT_W'(LANES);
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
